/* rtl/sgc_pkg.sv */
// Package with shared constants, types and codes of the steering grid correlator.
`default_nettype none
package sgc_pkg;
    localparam int DEF_THETA_CELLS = 8;
    localparam int DEF_PHI_CELLS   = 8;
    localparam int TABLE_DEPTH     = 64;
    localparam int CELL_W          = 6;
    localparam int SMP_W           = 16;
    localparam int CFG_IDX_W       = 4;
    localparam int CAL_REGS        = 8;
    localparam int MUL_A_W         = 34;
    localparam int MUL_B_W         = 20;
    localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
    localparam int ACC_W           = 51;
    localparam int RND_W           = 19;
    localparam int SSQ_W           = 36;
    localparam int ROOT_W          = 19;
    localparam logic [SMP_W-1:0] CAL_RE_RST = 16'h7FFF;
    localparam logic [SMP_W-1:0] CAL_IM_RST = 16'h0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_RND,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_ROOT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_ER_CR = 3'd0,
        OP_EI_CI = 3'd1,
        OP_ER_CI = 3'd2,
        OP_EI_CR = 3'd3,
        OP_A_SR  = 3'd4,
        OP_B_SI  = 3'd5,
        OP_B_SR  = 3'd6,
        OP_A_SI  = 3'd7
    } t_mop;

    typedef logic [7:0][SMP_W-1:0] t_cvec;
endpackage
`default_nettype wire

/* rtl/sgc_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module sgc_mul
    import sgc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic signed [MUL_A_W-1:0] i_a,
    input  wire logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0]      o_p
);
    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

/* rtl/sgc_isqrt.sv */
// Bit-serial integer square root with round to nearest, two radicand bits a cycle.
`default_nettype none
module sgc_isqrt
    import sgc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SSQ_W-1:0]  i_x,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);
    localparam int Q_W   = SSQ_W / 2;
    localparam int R_W   = Q_W + 2;
    localparam int T_W   = R_W + 2;
    localparam int CNT_W = $clog2(Q_W);

    logic              r_run;
    logic              r_fin;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SSQ_W-1:0]  r_x;
    logic [Q_W-1:0]    r_q;
    logic [R_W-1:0]    r_r;
    logic [ROOT_W-1:0] r_root;
    logic [T_W-1:0]    n_rem;
    logic [T_W-1:0]    n_trial;
    logic              n_ge;

    always_comb begin
        n_rem   = {r_r, r_x[SSQ_W-1 -: 2]};
        n_trial = {2'b00, r_q, 2'b01};
        n_ge    = (n_rem >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_fin <= 1'b0;
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_q   <= '0;
            r_r   <= '0;
            r_cnt <= CNT_W'(Q_W - 1);
        end else if (r_run) begin
            r_x   <= {r_x[SSQ_W-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (n_ge) begin
                r_r <= R_W'(n_rem - n_trial);
                r_q <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_r <= R_W'(n_rem);
                r_q <= {r_q[Q_W-2:0], 1'b0};
            end
        end else if (r_fin) begin
            r_root <= ROOT_W'(r_q) + ROOT_W'(r_r > R_W'(r_q));
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

/* rtl/steering_grid_correlator_unit.sv */
// Top level of the steering grid correlator: sequencer, steering table and accumulators.
//
// A load item (req_type 0) writes one cell's four steering values into the table in
// the cycle it is accepted and leaves busy low. A scan item (req_type 1) holds busy high
// while every cell of the grid, up to the table depth, is worked through one shared
// multiplier: per cell a table read, the multiplier steps for the four calibrated complex
// products, a rounding step, the squaring of both parts and the bit-serial square root,
// then an output step. Each result appears on the output ports for one cycle with o_valid
// high and cannot be stalled; o_last marks the final cell. Calibration is written through
// the config channel; the user must write it only while the block is idle, since the
// block itself does not enforce this. The channel is always ready.
`default_nettype none
module steering_grid_correlator_unit
    import sgc_pkg::*;
#(
    parameter int THETA_CELLS = DEF_THETA_CELLS,
    parameter int PHI_CELLS   = DEF_PHI_CELLS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_req_type,
    input  wire logic [CELL_W-1:0]       i_cell_index,
    input  wire logic signed [SMP_W-1:0] i_ant_a_re,
    input  wire logic signed [SMP_W-1:0] i_ant_a_im,
    input  wire logic signed [SMP_W-1:0] i_ant_b_re,
    input  wire logic signed [SMP_W-1:0] i_ant_b_im,
    input  wire logic signed [SMP_W-1:0] i_ant_c_re,
    input  wire logic signed [SMP_W-1:0] i_ant_c_im,
    input  wire logic signed [SMP_W-1:0] i_ant_d_re,
    input  wire logic signed [SMP_W-1:0] i_ant_d_im,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [SMP_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic [CELL_W-1:0]            o_grid_cell,
    output logic [SMP_W-1:0]             o_magnitude,
    output logic                         o_last
);
    localparam int GRID_CELLS = THETA_CELLS * PHI_CELLS;
    localparam int CELLS = (GRID_CELLS > TABLE_DEPTH) ? TABLE_DEPTH : GRID_CELLS;
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam int STEPS = 32;
    localparam int STEP_W = $clog2(STEPS) + 1;

    t_state r_state;
    t_state n_state;

    t_cvec r_mem [TABLE_DEPTH];
    t_cvec r_ent;
    t_cvec r_smp;
    t_cvec r_cal;

    logic [CELL_W-1:0]        r_cell;
    logic [STEP_W-1:0]        r_step;
    logic                     r_pvld;
    t_mop                     r_pop;
    logic signed [32:0]       r_a;
    logic signed [32:0]       r_b;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;
    logic signed [RND_W-1:0]  r_rr;
    logic signed [RND_W-1:0]  r_ri;
    logic [SSQ_W-1:0]         r_ssq;
    logic                     r_out_vld;
    logic [CELL_W-1:0]        r_out_cell;
    logic [SMP_W-1:0]         r_out_mag;
    logic                     r_out_last;

    logic                     n_issue;
    t_mop                     n_op;
    logic [2:0]               n_re_i;
    logic [2:0]               n_im_i;
    logic signed [MUL_A_W-1:0] n_mul_a;
    logic signed [MUL_B_W-1:0] n_mul_b;
    logic signed [MUL_P_W-1:0] w_p;
    logic                     n_sq_start;
    logic [SSQ_W-1:0]         n_ssq;
    logic signed [ACC_W-1:0]  n_t_re;
    logic signed [ACC_W-1:0]  n_t_im;
    logic                     w_sq_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     n_scan_acc;
    logic                     n_load_acc;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign n_scan_acc  = start && !busy && i_req_type;
    assign n_load_acc  = start && !busy && !i_req_type;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (n_scan_acc) n_state = S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  if (r_step == STEP_W'(STEPS)) n_state = S_RND;
            S_RND:  n_state = S_SQ0;
            S_SQ0:  n_state = S_SQ1;
            S_SQ1:  n_state = S_SQ2;
            S_SQ2:  n_state = S_ROOT;
            S_ROOT: if (w_sq_done) n_state = S_OUT;
            S_OUT:  n_state = (r_cell == LAST_CELL) ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_issue    = (r_state == S_MUL) && (r_step < STEP_W'(STEPS));
        n_op       = t_mop'(r_step[2:0]);
        n_re_i     = {r_step[4:3], 1'b0};
        n_im_i     = {r_step[4:3], 1'b1};
        n_sq_start = (r_state == S_SQ2);
        n_ssq      = r_ssq + SSQ_W'(w_p);
        n_t_re     = r_acc_re + (ACC_W'(1) <<< 31);
        n_t_im     = r_acc_im + (ACC_W'(1) <<< 31);
        n_mul_a    = '0;
        n_mul_b    = '0;
        case (r_state)
            S_MUL: begin
                case (n_op)
                    OP_ER_CR: begin
                        n_mul_a = MUL_A_W'(signed'(r_ent[n_re_i]));
                        n_mul_b = MUL_B_W'(signed'(r_cal[n_re_i]));
                    end
                    OP_EI_CI: begin
                        n_mul_a = MUL_A_W'(signed'(r_ent[n_im_i]));
                        n_mul_b = MUL_B_W'(signed'(r_cal[n_im_i]));
                    end
                    OP_ER_CI: begin
                        n_mul_a = MUL_A_W'(signed'(r_ent[n_re_i]));
                        n_mul_b = MUL_B_W'(signed'(r_cal[n_im_i]));
                    end
                    OP_EI_CR: begin
                        n_mul_a = MUL_A_W'(signed'(r_ent[n_im_i]));
                        n_mul_b = MUL_B_W'(signed'(r_cal[n_re_i]));
                    end
                    OP_A_SR: begin
                        n_mul_a = MUL_A_W'(r_a);
                        n_mul_b = MUL_B_W'(signed'(r_smp[n_re_i]));
                    end
                    OP_B_SI: begin
                        n_mul_a = MUL_A_W'(r_b);
                        n_mul_b = MUL_B_W'(signed'(r_smp[n_im_i]));
                    end
                    OP_B_SR: begin
                        n_mul_a = MUL_A_W'(r_b);
                        n_mul_b = MUL_B_W'(signed'(r_smp[n_re_i]));
                    end
                    OP_A_SI: begin
                        n_mul_a = MUL_A_W'(r_a);
                        n_mul_b = MUL_B_W'(signed'(r_smp[n_im_i]));
                    end
                    default: begin
                        n_mul_a = '0;
                        n_mul_b = '0;
                    end
                endcase
            end
            S_SQ0: begin
                n_mul_a = MUL_A_W'(r_rr);
                n_mul_b = MUL_B_W'(r_rr);
            end
            S_SQ1: begin
                n_mul_a = MUL_A_W'(r_ri);
                n_mul_b = MUL_B_W'(r_ri);
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    sgc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (w_p)
    );

    sgc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_sq_start),
        .i_x     (n_ssq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (n_load_acc) begin
            r_mem[i_cell_index] <= {i_ant_d_im, i_ant_d_re, i_ant_c_im, i_ant_c_re,
                                    i_ant_b_im, i_ant_b_re, i_ant_a_im, i_ant_a_re};
        end
        r_ent <= r_mem[r_cell];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pvld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < CAL_REGS / 2; k++) begin
                r_cal[2*k]   <= CAL_RE_RST;
                r_cal[2*k+1] <= CAL_IM_RST;
            end
        end else begin
            r_state   <= n_state;
            r_pvld    <= n_issue;
            r_out_vld <= (r_state == S_OUT);
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CAL_REGS))) begin
                r_cal[i_cfg_index[2:0]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop <= n_op;
        if (n_scan_acc) begin
            r_smp  <= {i_ant_d_im, i_ant_d_re, i_ant_c_im, i_ant_c_re,
                       i_ant_b_im, i_ant_b_re, i_ant_a_im, i_ant_a_re};
            r_cell <= '0;
        end
        if (r_state == S_RD) begin
            r_step   <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end
        if (n_issue) begin
            r_step <= r_step + 1'b1;
        end
        if (r_pvld) begin
            case (r_pop)
                OP_ER_CR: r_a <= w_p[32:0];
                OP_EI_CI: r_a <= r_a - w_p[32:0];
                OP_ER_CI: r_b <= w_p[32:0];
                OP_EI_CR: r_b <= r_b + w_p[32:0];
                OP_A_SR:  r_acc_re <= r_acc_re + w_p[ACC_W-1:0];
                OP_B_SI:  r_acc_re <= r_acc_re + w_p[ACC_W-1:0];
                OP_B_SR:  r_acc_im <= r_acc_im + w_p[ACC_W-1:0];
                OP_A_SI:  r_acc_im <= r_acc_im - w_p[ACC_W-1:0];
                default:  r_a <= r_a;
            endcase
        end
        if (r_state == S_RND) begin
            r_rr <= n_t_re[ACC_W-1:32];
            r_ri <= n_t_im[ACC_W-1:32];
        end
        if (r_state == S_SQ1) begin
            r_ssq <= w_p[SSQ_W-1:0];
        end
        if (r_state == S_OUT) begin
            r_out_cell <= r_cell;
            r_out_last <= (r_cell == LAST_CELL);
            r_out_mag  <= (w_root > ROOT_W'(16'hFFFF)) ? 16'hFFFF : w_root[SMP_W-1:0];
            r_cell     <= r_cell + 1'b1;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_grid_cell = r_out_cell;
    assign o_magnitude = r_out_mag;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> busy)
        else $error("Scan item did not raise busy.");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |=> !busy)
        else $error("Load item raised busy.");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("Scan stopped before its final cell.");
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_grid_cell == LAST_CELL))
        else $error("Final marker on a cell other than the last.");
`endif
endmodule
`default_nettype wire
